// ===== hw/rtl/sbq_pkg.sv =====
// Shared types and constants for the stereo biquad filter.
package sbq_pkg;

  // Coefficient word: signed Q3.20.
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned NUM_COEFS = 5;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_e;

  // One coefficient set, shared by both channels.
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

endpackage

// ===== hw/rtl/sbq_coef_regs.sv =====
// Coefficient register file with its write port.
module sbq_coef_regs #(
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [sbq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbq_pkg::COEF_W-1:0]     cfg_data_i,
  output sbq_pkg::coef_set_t             coef_o
);

  // Unity gain; bits beyond the coefficient word drop out.
  localparam logic [sbq_pkg::COEF_W-1:0] B0_RESET =
    sbq_pkg::COEF_W'(1) << COEF_FRAC_BITS;

  sbq_pkg::coef_set_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= B0_RESET;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbq_pkg::COEF_B0: coef_q.b0 <= cfg_data_i;
        sbq_pkg::COEF_B1: coef_q.b1 <= cfg_data_i;
        sbq_pkg::COEF_B2: coef_q.b2 <= cfg_data_i;
        sbq_pkg::COEF_A1: coef_q.a1 <= cfg_data_i;
        sbq_pkg::COEF_A2: coef_q.a2 <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== hw/rtl/sbq_channel.sv =====
// One channel: direct-form-I datapath with its delay line.
module sbq_channel #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  sbq_pkg::coef_set_t             coef_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o
);

  localparam int unsigned PROD_W = SAMPLE_WIDTH + sbq_pkg::COEF_W;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned EXT_W  = ACC_W - PROD_W;
  localparam int unsigned UP_W   = ACC_W - SAMPLE_WIDTH + 1;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] xh1_q, xh2_q, yh1_q, yh2_q;
  logic signed [PROD_W-1:0]       p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]        e0, e1, e2, e3, e4;
  logic signed [ACC_W-1:0]        acc, acc_rnd, acc_sh;
  logic [UP_W-1:0]                upper;
  logic                           in_range;

  assign p0 = x_i   * coef_i.b0;
  assign p1 = xh1_q * coef_i.b1;
  assign p2 = xh2_q * coef_i.b2;
  assign p3 = yh1_q * coef_i.a1;
  assign p4 = yh2_q * coef_i.a2;

  assign e0 = $signed({{EXT_W{p0[PROD_W-1]}}, p0});
  assign e1 = $signed({{EXT_W{p1[PROD_W-1]}}, p1});
  assign e2 = $signed({{EXT_W{p2[PROD_W-1]}}, p2});
  assign e3 = $signed({{EXT_W{p3[PROD_W-1]}}, p3});
  assign e4 = $signed({{EXT_W{p4[PROD_W-1]}}, p4});

  assign acc     = e0 + e1 + e2 - e3 - e4;
  assign acc_rnd = acc + HALF;
  assign acc_sh  = acc_rnd >>> COEF_FRAC_BITS;  // floor after half-LSB add

  // Fits when all bits from the sample sign upward agree.
  assign upper    = acc_sh[ACC_W-1:SAMPLE_WIDTH-1];
  assign in_range = (&upper) || (~|upper);

  always_comb begin
    if (in_range) begin
      y_o = acc_sh[SAMPLE_WIDTH-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      y_o = SMIN;
    end else begin
      y_o = SMAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh1_q <= '0;
      xh2_q <= '0;
      yh1_q <= '0;
      yh2_q <= '0;
    end else if (adv_i) begin
      xh1_q <= x_i;
      xh2_q <= xh1_q;
      yh1_q <= y_o;
      yh2_q <= yh1_q;
    end
  end

endmodule

// ===== hw/rtl/stereo_biquad_iir_filter.sv =====
// Stereo biquad IIR filter, direct form I, shared Q3.20 coefficients.
// A transaction passes through the input register, then the result register.
// Throughput: one stereo transaction per cycle while the output is not stalled; the five products per channel and
// the feedback through the output history close within the single compute stage.
// Reset (async, active low) clears the delay lines, empties both stages and loads
// b0 = 1.0 with all other coefficients zero.
module stereo_biquad_iir_filter #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in_i,
  // filtered output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_out_o,
  // coefficient writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbq_pkg::COEF_W-1:0]     cfg_data_i
);

  sbq_pkg::coef_set_t coef;

  logic                           s1_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_left_q, s1_right_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_left_q, out_right_q;
  logic signed [SAMPLE_WIDTH-1:0] y_left, y_right;

  logic out_free;  // result register can take a new transaction this cycle
  logic s1_adv;    // compute stage commits: history updates, result captured
  logic in_take;   // input transaction accepted

  // Coefficients are to be written by the user only while the filter is idle; the
  // block does not enforce this, so writes are always taken.
  assign cfg_ready_o = 1'b1;

  sbq_coef_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // Handshake: the result register empties or drains, then the input
  // register can move forward, then a new transaction can come in.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Both channels share the coefficient set but keep their own delay lines.
  sbq_channel #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .x_i    (s1_left_q),
    .coef_i (coef),
    .y_o    (y_left)
  );

  sbq_channel #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .x_i    (s1_right_q),
    .coef_i (coef),
    .y_o    (y_right)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_left_q  <= left_in_i;
      s1_right_q <= right_in_i;
    end
    if (s1_adv) begin
      out_left_q  <= y_left;
      out_right_q <= y_right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_left_q;
  assign right_out_o = out_right_q;

endmodule

// ===== hw/rtl/sbq_checker.sv =====
// Port-level checks for the stereo biquad filter, bound to the top level.
module sbq_checker #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [SAMPLE_WIDTH-1:0] left_out_o,
  input logic [SAMPLE_WIDTH-1:0] right_out_o
);

  // Nothing is shown during reset.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // Input only backs up when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // After an accepted transaction, a result is shown once the input and result registers have been passed.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o)
    else $error("no result after accepted transaction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(left_out_o) && $stable(right_out_o)))
    else $error("stalled result changed");

endmodule

bind stereo_biquad_iir_filter sbq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sbq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .left_out_o  (left_out_o),
  .right_out_o (right_out_o)
);
